### src/mrp_pkg.sv
// package with constants and types for the motor ramp pwm duty block
package mrp_pkg;

   localparam int POWER_W  = 7;
   localparam int DUTY_W   = 8;
   localparam int RAMP_W   = 8;
   localparam int PROD_W   = POWER_W + DUTY_W;
   localparam int RECIP_W  = 13;
   localparam int RECIP_SH = 19;
   localparam int QMUL_W   = PROD_W + RECIP_W;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [POWER_W-1:0] FULL_POWER = 7'd100;
   // ceil(2^19 / 100), exact for products below 25600
   localparam logic [RECIP_W-1:0] DIV100_RECIP = 13'd5243;

   localparam logic [DUTY_W-1:0] PWM_PERIOD_RESET = 8'd99;

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_TRIM  = 2'd2;

   typedef struct packed {
      logic               dir_right;
      logic               dir_left;
      logic [POWER_W-1:0] ramp_step;
      logic [POWER_W-1:0] goal_power;
   } req_type;

   // applied powers waiting for the duty stage
   typedef struct packed {
      logic               ramp_done;
      logic               dir_left;
      logic               dir_right;
      logic [POWER_W-1:0] left_level;
      logic [POWER_W-1:0] right_level;
      logic [PROD_W-1:0]  left_prod;
      logic [PROD_W-1:0]  right_prod;
   } apply_type;

   typedef struct packed {
      logic               pad;
      logic               ramp_done;
      logic [POWER_W-1:0] right_level;
      logic [POWER_W-1:0] left_level;
      logic [DUTY_W-1:0]  right_neg_duty;
      logic [DUTY_W-1:0]  right_pos_duty;
      logic [DUTY_W-1:0]  left_neg_duty;
      logic [DUTY_W-1:0]  left_pos_duty;
   } rsp_type;

endpackage

### src/motor_ramp_pwm_duty.sv
// motor ramp pwm duty: soft-start ramp and h-bridge duty generation for two motors
// a result passes through the input, apply and result registers before it is presented
// throughput: one request per cycle; the three register stages share one stall enable
// set by the result register, so a request enters whenever that register is free or taken
// reset: synchronous, clears powers, ramp state and valids; pwm_period returns to 99
module motor_ramp_pwm_duty (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // goal_power[6:0], ramp_step[13:7], dir_left[14], dir_right[15]
   input  logic [mrp_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // left_pos_duty[7:0], left_neg_duty[15:8], right_pos_duty[23:16], right_neg_duty[31:24],
   // left_level[38:32], right_level[45:39], ramp_done[46], zero[47]
   output logic [mrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mrp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mrp_pkg::DUTY_W-1:0]     csr_data
);
   import mrp_pkg::*;

   // configuration
   logic [DUTY_W-1:0]  pwm_period_ff;
   logic               brake_mode_ff;
   logic [POWER_W-1:0] left_trim_ff;

   // ramp state
   logic [POWER_W-1:0] left_power_ff, left_power_in;
   logic [POWER_W-1:0] right_power_ff, right_power_in;
   logic [RAMP_W-1:0]  ramp_value_ff, ramp_value_in;
   logic               ramp_active_ff, ramp_active_in;
   logic               ramp_upward_ff, ramp_upward_in;
   logic [POWER_W-1:0] held_target_ff, held_target_in;
   logic [POWER_W-1:0] held_step_ff, held_step_in;
   logic               left_direction_ff, left_direction_in;
   logic               right_direction_ff, right_direction_in;

   // pipeline
   logic      advance;
   logic      in_valid_ff;
   logic      in_op_ff;
   req_type   in_req_ff;
   logic      apply_valid_ff, apply_valid_in;
   apply_type apply_ff, apply_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   // state update locals
   logic [POWER_W-1:0] cmd_target;
   logic [POWER_W-1:0] cmd_step;
   logic [RAMP_W:0]    up_sum;
   logic [RAMP_W:0]    down_sum;
   logic               fits;
   logic [RAMP_W-1:0]  final_sum;

   // duty stage locals
   logic [QMUL_W-1:0]  left_q, right_q;
   logic [DUTY_W-1:0]  left_duty, right_duty;
   logic [DUTY_W-1:0]  left_p, left_n, right_p, right_n;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= PWM_PERIOD_RESET;
         brake_mode_ff <= 1'b0;
         left_trim_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PWM_PERIOD: pwm_period_ff <= csr_data;
            CSR_BRAKE_MODE: brake_mode_ff <= csr_data[0];
            CSR_LEFT_TRIM:  left_trim_ff  <= csr_data[POWER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd_target = (in_req_ff.goal_power > FULL_POWER) ? FULL_POWER
                                                       : in_req_ff.goal_power;
      cmd_step   = (in_req_ff.ramp_step == '0) ? POWER_W'(1) : in_req_ff.ramp_step;
      up_sum     = {1'b0, ramp_value_ff} + (RAMP_W+1)'(held_step_ff);
      down_sum   = (RAMP_W+1)'(held_target_ff) + (RAMP_W+1)'(held_step_ff);
      fits       = ramp_upward_ff ? (up_sum <= (RAMP_W+1)'(held_target_ff))
                                  : ({1'b0, ramp_value_ff} >= down_sum);
      final_sum  = RAMP_W'(held_target_ff) + RAMP_W'(left_trim_ff);

      left_power_in      = left_power_ff;
      right_power_in     = right_power_ff;
      ramp_value_in      = ramp_value_ff;
      ramp_active_in     = ramp_active_ff;
      ramp_upward_in     = ramp_upward_ff;
      held_target_in     = held_target_ff;
      held_step_in       = held_step_ff;
      left_direction_in  = left_direction_ff;
      right_direction_in = right_direction_ff;
      apply_valid_in     = 1'b0;
      apply_in.ramp_done = 1'b0;

      if (in_valid_ff) begin
         if (in_op_ff == OP_COMMAND) begin
            left_direction_in  = in_req_ff.dir_left;
            right_direction_in = in_req_ff.dir_right;
            held_target_in     = cmd_target;
            held_step_in       = cmd_step;
            ramp_value_in      = RAMP_W'(left_power_ff);
            if (cmd_target > left_power_ff && cmd_target > right_power_ff) begin
               ramp_active_in = 1'b1;
               ramp_upward_in = 1'b1;
            end else if (cmd_target < left_power_ff && cmd_target < right_power_ff) begin
               ramp_active_in = 1'b1;
               ramp_upward_in = 1'b0;
            end else begin
               ramp_active_in = 1'b0;
            end
         end else if (ramp_active_ff) begin
            apply_valid_in = 1'b1;
            if (fits) begin
               left_power_in  = ramp_value_ff[POWER_W-1:0];
               right_power_in = ramp_value_ff[POWER_W-1:0];
               ramp_value_in  = ramp_upward_ff ? up_sum[RAMP_W-1:0]
                                               : ramp_value_ff - RAMP_W'(held_step_ff);
            end else begin
               // imbalance is dropped when it would push left past full power
               left_power_in      = (final_sum > RAMP_W'(FULL_POWER)) ? held_target_ff
                                                                      : final_sum[POWER_W-1:0];
               right_power_in     = held_target_ff;
               ramp_active_in     = 1'b0;
               apply_in.ramp_done = 1'b1;
            end
         end
      end

      apply_in.dir_left    = left_direction_in;
      apply_in.dir_right   = right_direction_in;
      apply_in.left_level  = left_power_in;
      apply_in.right_level = right_power_in;
      apply_in.left_prod   = PROD_W'(left_power_in) * PROD_W'(pwm_period_ff);
      apply_in.right_prod  = PROD_W'(right_power_in) * PROD_W'(pwm_period_ff);
   end

   always_comb begin
      // divide by 100 through the reciprocal
      left_q     = QMUL_W'(apply_ff.left_prod) * QMUL_W'(DIV100_RECIP);
      right_q    = QMUL_W'(apply_ff.right_prod) * QMUL_W'(DIV100_RECIP);
      left_duty  = left_q[RECIP_SH +: DUTY_W];
      right_duty = right_q[RECIP_SH +: DUTY_W];

      if (brake_mode_ff) begin
         left_p  = pwm_period_ff - left_duty;
         left_n  = pwm_period_ff;
         right_p = pwm_period_ff - right_duty;
         right_n = pwm_period_ff;
      end else begin
         left_p  = '0;
         left_n  = left_duty;
         right_p = '0;
         right_n = right_duty;
      end

      rsp_in.pad            = 1'b0;
      rsp_in.ramp_done      = apply_ff.ramp_done;
      rsp_in.left_level     = apply_ff.left_level;
      rsp_in.right_level    = apply_ff.right_level;
      // reverse direction swaps the bridge sides
      rsp_in.left_pos_duty  = apply_ff.dir_left  ? left_p  : left_n;
      rsp_in.left_neg_duty  = apply_ff.dir_left  ? left_n  : left_p;
      rsp_in.right_pos_duty = apply_ff.dir_right ? right_p : right_n;
      rsp_in.right_neg_duty = apply_ff.dir_right ? right_n : right_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         apply_valid_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         left_power_ff      <= '0;
         right_power_ff     <= '0;
         ramp_value_ff      <= '0;
         ramp_active_ff     <= 1'b0;
         ramp_upward_ff     <= 1'b0;
         held_target_ff     <= '0;
         held_step_ff       <= POWER_W'(1);
         left_direction_ff  <= 1'b0;
         right_direction_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff        <= req_tvalid;
         apply_valid_ff     <= apply_valid_in;
         rsp_valid_ff       <= apply_valid_ff;
         left_power_ff      <= left_power_in;
         right_power_ff     <= right_power_in;
         ramp_value_ff      <= ramp_value_in;
         ramp_active_ff     <= ramp_active_in;
         ramp_upward_ff     <= ramp_upward_in;
         held_target_ff     <= held_target_in;
         held_step_ff       <= held_step_in;
         left_direction_ff  <= left_direction_in;
         right_direction_ff <= right_direction_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_op_ff  <= req_tuser;
         in_req_ff <= req_tdata;
         apply_ff  <= apply_in;
         rsp_ff    <= rsp_in;
      end
   end

endmodule

### sim/tb_motor_ramp_pwm_duty.sv
// testbench for the motor ramp pwm duty block: random stream traffic checked by a predicting scoreboard
module tb_motor_ramp_pwm_duty;
   import mrp_pkg::*;

   class duty_scoreboard;
      int unsigned pwm_period;
      bit          brake_mode;
      int unsigned left_trim;
      int unsigned left_power;
      int unsigned right_power;
      int unsigned ramp_value;
      bit          ramp_active;
      bit          ramp_upward;
      int unsigned held_target;
      int unsigned held_step;
      bit          left_dir;
      bit          right_dir;
      rsp_type     duty_expect_q[$];
      int unsigned mismatch_count;

      function new();
         pwm_period      = PWM_PERIOD_RESET;
         brake_mode      = 1'b0;
         left_trim       = 0;
         left_power      = 0;
         right_power     = 0;
         ramp_value      = 0;
         ramp_active     = 1'b0;
         ramp_upward     = 1'b0;
         held_target     = 0;
         held_step       = 1;
         left_dir        = 1'b0;
         right_dir       = 1'b0;
         mismatch_count  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] val);
         case (idx)
            CSR_PWM_PERIOD: begin
               pwm_period = val;
            end
            CSR_BRAKE_MODE: begin
               brake_mode = val[0];
            end
            CSR_LEFT_TRIM: begin
               left_trim = val[POWER_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // h-bridge side duties for one motor
      function void drive_pair(int unsigned power, bit dir,
                               output logic [DUTY_W-1:0] pos, output logic [DUTY_W-1:0] neg);
         int unsigned duty;
         int unsigned p;
         int unsigned n;
         duty = (power * pwm_period) / FULL_POWER;
         if (brake_mode) begin
            p = pwm_period - duty;
            n = pwm_period;
         end else begin
            p = 0;
            n = duty;
         end
         if (dir) begin
            pos = DUTY_W'(p);
            neg = DUTY_W'(n);
         end else begin
            pos = DUTY_W'(n);
            neg = DUTY_W'(p);
         end
      endfunction

      function void push_applied(bit done);
         rsp_type e;
         e = '0;
         drive_pair(left_power, left_dir, e.left_pos_duty, e.left_neg_duty);
         drive_pair(right_power, right_dir, e.right_pos_duty, e.right_neg_duty);
         e.left_level  = POWER_W'(left_power);
         e.right_level = POWER_W'(right_power);
         e.ramp_done   = done;
         duty_expect_q.push_back(e);
      endfunction

      // returns 1 when the request produces a result
      function bit apply_request(logic op, req_type r);
         int unsigned tgt;
         int unsigned stp;
         bit          fits;
         if (op == OP_COMMAND) begin
            tgt = r.goal_power;
            stp = r.ramp_step;
            if (tgt > FULL_POWER) tgt = FULL_POWER;
            if (stp == 0) stp = 1;
            left_dir    = r.dir_left;
            right_dir   = r.dir_right;
            held_target = tgt;
            held_step   = stp;
            ramp_value  = left_power;
            if (tgt > left_power && tgt > right_power) begin
               ramp_active = 1'b1;
               ramp_upward = 1'b1;
            end else if (tgt < left_power && tgt < right_power) begin
               ramp_active = 1'b1;
               ramp_upward = 1'b0;
            end else begin
               ramp_active = 1'b0;
            end
            return 1'b0;
         end
         if (!ramp_active) return 1'b0;
         if (ramp_upward) fits = (ramp_value + held_step) <= held_target;
         else fits = ramp_value >= (held_target + held_step);
         if (fits) begin
            left_power  = ramp_value;
            right_power = ramp_value;
            if (ramp_upward) ramp_value = (ramp_value + held_step) & 8'hFF;
            else ramp_value = (ramp_value - held_step) & 8'hFF;
            push_applied(1'b0);
         end else begin
            // imbalance only applies if the left sum stays in range
            if (held_target + left_trim > FULL_POWER) left_power = held_target;
            else left_power = held_target + left_trim;
            right_power = held_target;
            ramp_active = 1'b0;
            push_applied(1'b1);
         end
         return 1'b1;
      endfunction

      task report(string msg);
         $display("[%0t] %s", $time, msg);
         mismatch_count++;
      endtask

      task check_field(string name, logic [DUTY_W-1:0] got, logic [DUTY_W-1:0] want);
         if (got !== want) report($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
      endtask

      task check_duties(rsp_type got);
         rsp_type want;
         if (duty_expect_q.size() == 0) begin
            report($sformatf("result %h with no request pending", got));
            return;
         end
         want = duty_expect_q.pop_front();
         check_field("left_pos_duty", got.left_pos_duty, want.left_pos_duty);
         check_field("left_neg_duty", got.left_neg_duty, want.left_neg_duty);
         check_field("right_pos_duty", got.right_pos_duty, want.right_pos_duty);
         check_field("right_neg_duty", got.right_neg_duty, want.right_neg_duty);
         check_field("left_level", got.left_level, want.left_level);
         check_field("right_level", got.right_level, want.right_level);
         check_field("ramp_done", got.ramp_done, want.ramp_done);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [DUTY_W-1:0]      csr_data;

   duty_scoreboard sb = new();
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_idle_pct = 0;
   int unsigned    items_sent = 0;

   motor_ramp_pwm_duty uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("[motor_ramp_pwm_duty] ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_duties(rsp_type'(rsp_tdata));
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_request(input logic op, input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      void'(sb.apply_request(op, r));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_command(input logic [POWER_W-1:0] tgt, input logic [POWER_W-1:0] stp,
                               input logic dl, input logic dr);
      req_type r;
      r.goal_power = tgt;
      r.ramp_step  = stp;
      r.dir_left   = dl;
      r.dir_right  = dr;
      send_request(OP_COMMAND, r);
   endtask

   // tick payload is don't-care, so it gets random bits
   task automatic send_tick();
      send_request(OP_TICK, req_type'(REQ_DATA_W'($urandom)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.duty_expect_q.size() != 0) @(posedge clock);
      // ticks that produce nothing may still be in the pipe
      repeat (6) @(negedge clock);
   endtask

   task automatic configure(input logic [DUTY_W-1:0] period, input logic brake,
                            input logic [POWER_W-1:0] imbalance);
      logic [DUTY_W-1:0] vals [3];
      vals[0] = period;
      vals[1] = {7'd0, brake};
      vals[2] = {1'b0, imbalance};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_register(CSR_IDX_W'(i), vals[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly a command followed by enough ticks to finish its ramp, plus some noise
   task automatic run_random(input int unsigned count);
      int unsigned start;
      int unsigned tgt;
      int unsigned stp;
      int unsigned gap;
      int unsigned ticks;
      int unsigned roll;
      start = items_sent;
      while (items_sent - start < count) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            tgt = ($urandom_range(9) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
            stp = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(25, 1);
            send_command(POWER_W'(tgt), POWER_W'(stp),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            if (tgt > FULL_POWER) tgt = FULL_POWER;
            if (stp == 0) stp = 1;
            gap = (tgt > sb.left_power) ? tgt - sb.left_power : sb.left_power - tgt;
            ticks = gap / stp + 1 + $urandom_range(2);
            // occasionally cut the ramp short
            if ($urandom_range(9) == 0) ticks = $urandom_range(ticks);
            repeat (ticks) send_tick();
         end else if (roll < 93) begin
            send_tick();
         end else begin
            send_command(POWER_W'($urandom_range(127)), POWER_W'($urandom_range(127)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_COMMAND;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_PWM_PERIOD;
      csr_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 9;
      recv_idle_pct = 72;

      // directed part at reset settings
      send_tick();
      send_command(7'd2, 7'd0, 1'b1, 1'b1);
      repeat (3) send_tick();
      send_command(7'd127, 7'd127, 1'b0, 1'b0);
      send_tick();
      send_command(7'd100, 7'd50, 1'b1, 1'b0);
      send_tick();
      send_command(7'd0, 7'd40, 1'b1, 1'b0);
      repeat (3) send_tick();
      wait_drained();

      configure(8'd255, 1'b1, 7'd100);
      send_command(7'd1, 7'd1, 1'b1, 1'b0);
      repeat (2) send_tick();
      send_command(7'd50, 7'd10, 1'b0, 1'b1);
      send_tick();
      send_command(7'd1, 7'd5, 1'b1, 1'b1);
      send_tick();
      wait_drained();

      configure(8'd0, 1'b0, 7'd20);
      send_command(7'd30, 7'd100, 1'b1, 1'b1);
      send_tick();
      send_command(7'd40, 7'd7, 1'b0, 1'b0);
      send_tick();
      send_command(7'd10, 7'd127, 1'b1, 1'b0);
      send_tick();

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: configure(8'd99, 1'b0, 7'd0);
            1: configure(8'd255, 1'b1, 7'd127);
            2: configure(8'd0, 1'b1, 7'd10);
            3: configure(8'd100, 1'b0, 7'd100);
            default: configure(DUTY_W'($urandom_range(255)), 1'($urandom_range(1)),
                               POWER_W'($urandom_range(127)));
         endcase
         if (phase < 2) begin
            send_idle_pct = 9;
            recv_idle_pct = 72;
         end else if (phase < 4) begin
            send_idle_pct = 72;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 2) begin
            run_random(125);
            // hold off until the pipe has emptied, then resume
            wait_drained();
            run_random(120);
         end else begin
            run_random(245);
         end
      end

      req_tvalid <= 1'b0;
      while (sb.duty_expect_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.duty_expect_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.duty_expect_q.size()));
      if (sb.mismatch_count == 0) begin
         $display("[motor_ramp_pwm_duty] OK");
      end else begin
         $display("[motor_ramp_pwm_duty] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
src/mrp_pkg.sv
src/motor_ramp_pwm_duty.sv
sim/tb_motor_ramp_pwm_duty.sv
